FILE: hdl/ors_pkg.sv
package ors_pkg;

	// Code length; a device code is ROM_BYTES bytes, always held in a 64-bit word.
	localparam int unsigned ROM_BYTES = 8;
	localparam int unsigned CODE_BITS = ROM_BYTES * 8;
	localparam int unsigned CODE_W = 64;
	localparam int unsigned POS_W = 7;

	localparam logic [CODE_W-1:0] CODE_MASK =
		(CODE_BITS >= CODE_W) ? {CODE_W{1'b1}} : ((CODE_W'(1) << CODE_BITS) - CODE_W'(1));

	localparam logic [7:0] ECHO_NO_PRESENCE = 8'hF0;
	localparam logic [7:0] ECHO_ONE = 8'hFF;
	localparam logic [7:0] BYTE_ONE = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BIT = 1'b1;

	localparam logic [2:0] ST_BUSY = 3'd0;
	localparam logic [2:0] ST_DONE = 3'd1;
	localparam logic [2:0] ST_ABSENT = 3'd2;
	localparam logic [2:0] ST_FAULT = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_ABSENT = 2'd1;
	localparam logic [1:0] OP_BIT = 2'd2;

	// Queue between front and back.
	localparam int unsigned Q_AW = 1;
	localparam int unsigned Q_DEPTH = 2;

	typedef struct packed {
		logic cmd;
		logic [POS_W-1:0] start_discrepancy;
		logic [7:0] reset_echo;
		logic [7:0] bit_echo;
		logic [7:0] complement_echo;
	} item_t;

	typedef struct packed {
		logic [7:0] write_byte;
		logic write_valid;
		logic [2:0] status;
		logic [POS_W-1:0] next_discrepancy;
		logic [CODE_W-1:0] rom_code;
	} result_t;

	// Classified operation handed from the front to the back.
	typedef struct packed {
		logic [1:0] kind;
		logic [POS_W-1:0] disc;
		logic bit_one;
		logic comp_one;
	} op_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: hdl/ors_front.sv
module ors_front (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  ors_pkg::item_t item,
	input  ors_pkg::qstat_t qstat,
	output logic push,
	output ors_pkg::op_t push_op
);
	import ors_pkg::*;

	logic valid_s1;
	op_t op_s1;
	op_t op_cls;
	logic take;

	always_comb begin
		op_cls.disc = item.start_discrepancy;
		op_cls.bit_one = (item.bit_echo == ECHO_ONE);
		op_cls.comp_one = (item.complement_echo == ECHO_ONE);
		if (item.cmd == CMD_BIT) begin
			op_cls.kind = OP_BIT;
		end else if (item.reset_echo == ECHO_NO_PRESENCE) begin
			op_cls.kind = OP_ABSENT;
		end else begin
			op_cls.kind = OP_START;
		end
	end

	assign push = valid_s1 && !qstat.full;
	assign item_stall = valid_s1 && qstat.full;
	assign take = item_valid && !item_stall;
	assign push_op = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_cls;
		end
	end

endmodule

FILE: hdl/ors_queue.sv
module ors_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ors_pkg::op_t push_op,
	input  logic pop,
	output ors_pkg::op_t head_op,
	output ors_pkg::qstat_t qstat
);
	import ors_pkg::*;

	op_t entries_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0] count_q;

	assign qstat.full = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_op = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !qstat.full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !qstat.empty)
		else $error("queue read while empty");

endmodule

FILE: hdl/ors_back.sv
module ors_back (
	input  logic clk,
	input  logic arst_n,
	input  ors_pkg::op_t head_op,
	input  ors_pkg::qstat_t qstat,
	output logic pop,
	output logic result_valid,
	input  logic result_stall,
	output ors_pkg::result_t result
);
	import ors_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic [POS_W-1:0] bits_left_q;
	logic [POS_W-1:0] old_disc_q;
	logic [POS_W-1:0] new_disc_q;
	logic active_q;
	logic res_valid_q;
	result_t res_q;

	logic [CODE_W-1:0] code_n;
	logic [POS_W-1:0] bits_left_n;
	logic [POS_W-1:0] old_disc_n;
	logic [POS_W-1:0] new_disc_n;
	logic active_n;
	result_t res_n;
	logic conflict;
	logic take_one;
	logic chosen;
	logic [CODE_W-1:0] shifted;

	assign pop = !qstat.empty && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_comb begin
		conflict = !head_op.bit_one && !head_op.comp_one;
		// At a conflict the 1 branch is taken while the bit count is below the old discrepancy,
		// the 0 branch when it equals it, and the previous code's bit (now at bit 0) when above it.
		take_one = (old_disc_q > bits_left_q) || (code_q[0] && (old_disc_q != bits_left_q));
		chosen = head_op.bit_one || (conflict && take_one);
		shifted = (code_q & CODE_MASK) >> 1;
		shifted[CODE_BITS-1] = chosen;

		code_n = code_q;
		bits_left_n = bits_left_q;
		old_disc_n = old_disc_q;
		new_disc_n = new_disc_q;
		active_n = active_q;
		res_n.write_byte = BYTE_ZERO;
		res_n.write_valid = 1'b0;
		res_n.status = ST_IGNORED;
		res_n.rom_code = '0;

		case (head_op.kind)
			OP_START: begin
				new_disc_n = '0;
				active_n = 1'b1;
				bits_left_n = POS_W'(CODE_BITS);
				old_disc_n = head_op.disc;
				res_n.status = ST_BUSY;
			end
			OP_ABSENT: begin
				new_disc_n = '0;
				active_n = 1'b0;
				bits_left_n = '0;
				res_n.status = ST_ABSENT;
			end
			OP_BIT: begin
				if (!active_q) begin
					res_n.status = ST_IGNORED;
				end else if (head_op.bit_one && head_op.comp_one) begin
					active_n = 1'b0;
					res_n.status = ST_FAULT;
				end else begin
					if (conflict && take_one) begin
						new_disc_n = bits_left_q;
					end
					code_n = shifted;
					bits_left_n = (bits_left_q != '0) ? bits_left_q - 1'b1 : '0;
					res_n.write_byte = chosen ? BYTE_ONE : BYTE_ZERO;
					res_n.write_valid = 1'b1;
					if (bits_left_n == '0) begin
						active_n = 1'b0;
						res_n.status = ST_DONE;
						res_n.rom_code = shifted;
					end else begin
						res_n.status = ST_BUSY;
					end
				end
			end
			default: begin
				res_n.status = ST_IGNORED;
			end
		endcase
		res_n.next_discrepancy = new_disc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			bits_left_q <= '0;
			old_disc_q <= '0;
			new_disc_q <= '0;
			active_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				code_q <= code_n;
				bits_left_q <= bits_left_n;
				old_disc_q <= old_disc_n;
				new_disc_q <= new_disc_n;
				active_q <= active_n;
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (bits_left_q != '0) && (bits_left_q <= POS_W'(CODE_BITS)))
		else $error("active pass with bit count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_DONE) |-> res_q.write_valid && !active_q)
		else $error("finished pass without final write or still active");

endmodule

FILE: hdl/onewire_rom_search_core.sv
// A transaction accepted at the input is held in the front-end register, then in a queue
// entry, and its result is presented from the back end's output register.
// Throughput: one transaction per cycle on each side while neither side stalls; the back end
// updates the search state per operation, so a bit pair can follow the previous one directly.
// Reset: arst_n clears the search state, the queue and both valid flags at once.
module onewire_rom_search_core (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  ors_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output ors_pkg::result_t result
);
	import ors_pkg::*;

	// The front end registers each incoming transaction and decides what kind it is:
	// a start with a device present, a start with no presence pulse, or a bit pair.
	// The echo bytes are reduced to two flags there, so the back end sees only the
	// decoded operation.
	logic push;
	op_t push_op;
	op_t head_op;
	qstat_t qstat;
	logic pop;

	ors_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.qstat     (qstat),
		.push      (push),
		.push_op   (push_op)
	);

	// A two-entry queue decouples the front end from the back end, so that a stall
	// on the result side does not immediately reach the input side.
	ors_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head_op(head_op),
		.qstat  (qstat)
	);

	// The back end holds the search state: the code shift register, the bit count,
	// and the old and new discrepancies. It takes one operation from the queue
	// whenever its output register is free or being emptied in the same cycle, and
	// writes the result into that register.
	ors_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_op     (head_op),
		.qstat       (qstat),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

FILE: test/testbench.sv
module testbench;

	import ors_pkg::*;

	// Cycles in a row without any accepted transaction before the run is abandoned.
	// The deliberate receiver hold-off is far shorter than this.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Length of the deliberate receiver hold-off.
	localparam int unsigned HOLD_CYCLES = 300;
	// Rough number of accepted, non-ignored input transactions for the random part.
	localparam int unsigned ITEM_TARGET = 780;

	// The scoreboard carries its own copy of the search state. An accepted input
	// transaction is run through the search step at once, and the result it should
	// produce is queued until the block hands over its next result.
	class search_scoreboard;
		logic [CODE_W-1:0] code_shift;
		logic [POS_W-1:0] bits_left;
		logic [POS_W-1:0] old_disc;
		logic [POS_W-1:0] new_disc;
		bit active;
		result_t expected_q[$];
		int unsigned errors;

		function new();
			code_shift = '0;
			bits_left = '0;
			old_disc = '0;
			new_disc = '0;
			active = 1'b0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Advances the search state by one input transaction, queues the result it
		// must give and returns its status.
		function logic [2:0] note_item(item_t it);
			result_t want;
			logic [POS_W-1:0] pos;
			logic bit_one;
			logic comp_one;
			want = '0;
			if (it.cmd == CMD_START) begin
				new_disc = '0;
				if (it.reset_echo == ECHO_NO_PRESENCE) begin
					active = 1'b0;
					bits_left = '0;
					want.status = ST_ABSENT;
				end else begin
					active = 1'b1;
					bits_left = POS_W'(CODE_BITS);
					old_disc = it.start_discrepancy;
					want.status = ST_BUSY;
				end
			end else if (!active) begin
				want.status = ST_IGNORED;
			end else begin
				pos = bits_left;
				bit_one = (it.bit_echo == ECHO_ONE);
				comp_one = (it.complement_echo == ECHO_ONE);
				if (bit_one && comp_one) begin
					// Nobody answered either slot: the pass is lost, the code
					// register keeps what has been shifted in so far.
					active = 1'b0;
					want.status = ST_FAULT;
				end else begin
					if (!bit_one && !comp_one) begin
						// Devices disagree here; take the 1 branch first.
						if (old_disc > pos || (code_shift[0] && old_disc != pos)) begin
							bit_one = 1'b1;
							new_disc = pos;
						end
					end
					code_shift = (code_shift & CODE_MASK) >> 1;
					if (bit_one)
						code_shift[CODE_BITS-1] = 1'b1;
					if (bits_left != '0)
						bits_left = bits_left - 1'b1;
					want.write_byte = bit_one ? BYTE_ONE : BYTE_ZERO;
					want.write_valid = 1'b1;
					if (bits_left == '0) begin
						active = 1'b0;
						want.status = ST_DONE;
						want.rom_code = code_shift;
					end else begin
						want.status = ST_BUSY;
					end
				end
			end
			want.next_discrepancy = new_disc;
			expected_q.push_back(want);
			return want.status;
		endfunction

		task report(string what, logic [CODE_W-1:0] got, logic [CODE_W-1:0] want);
			errors++;
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report("result with nothing outstanding", CODE_W'(got.status), '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.write_byte !== want.write_byte)
				report("write_byte", CODE_W'(got.write_byte), CODE_W'(want.write_byte));
			if (got.write_valid !== want.write_valid)
				report("write_valid", CODE_W'(got.write_valid), CODE_W'(want.write_valid));
			if (got.status !== want.status)
				report("status", CODE_W'(got.status), CODE_W'(want.status));
			if (got.next_discrepancy !== want.next_discrepancy)
				report("next_discrepancy", CODE_W'(got.next_discrepancy),
					CODE_W'(want.next_discrepancy));
			if (got.rom_code !== want.rom_code)
				report("rom_code", got.rom_code, want.rom_code);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	search_scoreboard sb = new();

	// Flags shared between the stimulus and the receiver.
	// tx_calm and rx_calm switch the random idling of each side off; hold_request
	// asks the receiver for one long hold-off, which it times itself.
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_request = 1'b0;
	int unsigned items_counted = 0;

	onewire_rom_search_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver. The handshake is sampled right after the edge, before any of the
	// updates that the edge schedules, so it sees the values the block saw. The
	// stall for the next cycle is then chosen: either the long hold-off, when it
	// has been asked for, or a random stall with a chance of about 18 in a hundred.
	initial begin
		int unsigned hold_count;
		hold_count = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				sb.check_result(result);
			if (hold_request) begin
				result_stall <= 1'b1;
				hold_count++;
				if (hold_count >= HOLD_CYCLES) begin
					hold_count = 0;
					hold_request = 1'b0;
				end
			end else begin
				result_stall <= !rx_calm && ($urandom_range(99) < 18);
			end
		end
	end

	// Watchdog: a run that stops moving in either direction is a failure.
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic item_t mk_item(logic cmd, logic [POS_W-1:0] disc, logic [7:0] rst_echo,
			logic [7:0] b_echo, logic [7:0] c_echo);
		item_t it;
		it.cmd = cmd;
		it.start_discrepancy = disc;
		it.reset_echo = rst_echo;
		it.bit_echo = b_echo;
		it.complement_echo = c_echo;
		return it;
	endfunction

	// A slot that reads 1 echoes 0xFF; a 0 pulls some bits low, so any other byte.
	function automatic logic [7:0] echo_of(bit v);
		return v ? ECHO_ONE : 8'($urandom_range(254));
	endfunction

	// Any reset echo that shows a device on the bus.
	function automatic logic [7:0] presence_echo();
		logic [7:0] e;
		e = 8'($urandom);
		return (e == ECHO_NO_PRESENCE) ? 8'hE0 : e;
	endfunction

	// Offers one input transaction, possibly after a random gap, and holds it until
	// it is taken. The scoreboard is told at the edge that accepts it, so that the
	// caller can look at the updated search state before building the next one.
	task automatic send_item(input item_t it);
		logic [2:0] st;
		while (!tx_calm && $urandom_range(99) < 18) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(item_valid && !item_stall));
		st = sb.note_item(it);
		if (st != ST_IGNORED)
			items_counted++;
	endtask

	// Stops offering and waits until every outstanding result has been taken.
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// A complete search over a small set of simulated devices. The bus is a wired
	// AND, so the bit slot reads 1 only if every remaining device has a 1 there and
	// the complement slot only if every one has a 0. After each bit the devices that
	// do not match the branch the scoreboard chose drop out. The next pass starts from
	// the discrepancy the scoreboard holds, until no branch is left or eight passes have run.
	task automatic run_search(input int unsigned devices);
		logic [CODE_W-1:0] codes[4];
		bit alive[4];
		logic [POS_W-1:0] disc;
		logic rd_bit;
		logic rd_comp;
		logic chosen;
		int unsigned n_pass;
		int unsigned i;
		int unsigned d;
		// Devices share a random number of leading bits so that conflicts turn up
		// at every depth, not only in the first few slots.
		codes[0] = {$urandom, $urandom};
		for (d = 1; d < 4; d++)
			codes[d] = codes[0] ^ ({$urandom, $urandom} << $urandom_range(63));
		disc = ($urandom_range(9) == 0) ? POS_W'($urandom_range(127, 66)) : POS_W'(65);
		for (n_pass = 0; n_pass < 8; n_pass++) begin
			for (d = 0; d < 4; d++)
				alive[d] = (d < devices);
			send_item(mk_item(CMD_START, disc, presence_echo(), 8'($urandom), 8'($urandom)));
			for (i = 0; i < CODE_BITS; i++) begin
				rd_bit = 1'b1;
				rd_comp = 1'b1;
				for (d = 0; d < 4; d++) begin
					if (alive[d]) begin
						rd_bit &= codes[d][i];
						rd_comp &= !codes[d][i];
					end
				end
				send_item(mk_item(CMD_BIT, POS_W'($urandom), 8'($urandom),
					echo_of(rd_bit), echo_of(rd_comp)));
				chosen = sb.code_shift[CODE_BITS-1];
				for (d = 0; d < 4; d++)
					if (codes[d][i] != chosen)
						alive[d] = 1'b0;
			end
			disc = sb.new_disc;
			if (disc == '0)
				break;
		end
	endtask

	// A pass that does not follow a real bus: random discrepancy, arbitrary slot
	// pairs including both-one faults, sometimes no presence, and a length that may
	// fall short of the code or run past it.
	task automatic run_broken_pass();
		int unsigned k;
		int unsigned j;
		int unsigned kind;
		logic [7:0] rst_echo;
		rst_echo = ($urandom_range(7) == 0) ? ECHO_NO_PRESENCE : presence_echo();
		send_item(mk_item(CMD_START, POS_W'($urandom_range(127)), rst_echo,
			8'($urandom), 8'($urandom)));
		k = $urandom_range(70, 1);
		for (j = 0; j < k; j++) begin
			kind = $urandom_range(19);
			if (kind == 0)
				send_item(mk_item(CMD_BIT, POS_W'($urandom), 8'($urandom), ECHO_ONE, ECHO_ONE));
			else if (kind < 7)
				send_item(mk_item(CMD_BIT, POS_W'($urandom), 8'($urandom),
					ECHO_ONE, echo_of(1'b0)));
			else if (kind < 13)
				send_item(mk_item(CMD_BIT, POS_W'($urandom), 8'($urandom),
					echo_of(1'b0), ECHO_ONE));
			else
				send_item(mk_item(CMD_BIT, POS_W'($urandom), 8'($urandom),
					echo_of(1'b0), echo_of(1'b0)));
		end
	endtask

	// Short bursts of unrelated transactions with random fields.
	task automatic run_noise();
		int unsigned n;
		int unsigned j;
		n = $urandom_range(8, 1);
		for (j = 0; j < n; j++)
			send_item(mk_item(1'($urandom), POS_W'($urandom), 8'($urandom),
				($urandom_range(3) == 0) ? ECHO_ONE : 8'($urandom),
				($urandom_range(3) == 0) ? ECHO_ONE : 8'($urandom)));
	endtask

	initial begin
		int unsigned pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: bit pairs while idle, no presence, a fault, every way a
		// conflict can be settled, a start that abandons a running pass, and the
		// extremes of the discrepancy and echo fields.
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, ECHO_ONE, 8'h00));
		send_item(mk_item(CMD_START, 7'd65, ECHO_NO_PRESENCE, 8'h00, ECHO_ONE));
		send_item(mk_item(CMD_BIT, 7'd127, 8'hFF, 8'h00, ECHO_ONE));
		send_item(mk_item(CMD_START, 7'd0, 8'h00, ECHO_ONE, ECHO_ONE));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, ECHO_ONE, ECHO_ONE));
		send_item(mk_item(CMD_BIT, 7'd64, 8'hF0, 8'h00, ECHO_ONE));
		send_item(mk_item(CMD_START, 7'd127, 8'hFF, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd1, 8'h7F, 8'hFE, 8'h7F));
		send_item(mk_item(CMD_BIT, 7'd2, 8'h80, ECHO_ONE, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd3, 8'h01, 8'h00, ECHO_ONE));
		send_item(mk_item(CMD_BIT, 7'd4, 8'hFE, 8'h80, 8'hFE));
		send_item(mk_item(CMD_START, 7'd64, 8'hEF, 8'hFF, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd127, 8'hFF, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd127, 8'hFF, 8'h00, 8'h00));
		send_item(mk_item(CMD_START, 7'd62, 8'hF1, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, 8'h55, 8'hAA));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, 8'h00, 8'h00));
		send_item(mk_item(CMD_START, 7'd1, 8'h00, 8'h00, 8'h00));
		send_item(mk_item(CMD_BIT, 7'd0, 8'h00, 8'h00, 8'h00));
		send_item(mk_item(CMD_START, 7'd65, ECHO_NO_PRESENCE, ECHO_ONE, ECHO_ONE));
		drain();

		// Back-pressure: the receiver holds off for a long stretch while the sender
		// keeps offering without gaps, so the block fills up and stalls its input.
		hold_request = 1'b1;
		tx_calm = 1'b1;
		run_search(3);
		tx_calm = 1'b0;
		drain();

		// Random part: mostly complete searches, with broken passes and noise in
		// between. A stretch in the middle runs without idling on either side, and
		// now and then the sender stops until everything outstanding has arrived.
		items_counted = 0;
		while (items_counted < ITEM_TARGET) begin
			tx_calm = (items_counted >= 450 && items_counted < 650);
			rx_calm = tx_calm;
			pick = $urandom_range(99);
			if (pick < 65)
				run_search($urandom_range(4, 1));
			else if (pick < 82)
				run_broken_pass();
			else
				run_noise();
			if ($urandom_range(9) == 0)
				drain();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		// Wind down: wait for the last results, then keep the clock running so that any
		// stray result would still be caught.
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
hdl/ors_pkg.sv
hdl/ors_front.sv
hdl/ors_queue.sv
hdl/ors_back.sv
hdl/onewire_rom_search_core.sv
test/testbench.sv
